/* rtl/point_set_normalizer_macros.svh */
// Assertion macros for the point set normalizer checker.
`ifndef POINT_SET_NORMALIZER_MACROS_SVH
`define POINT_SET_NORMALIZER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PSN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/psn_pkg.sv */
// ----------------------------------------------------------------------------
// psn_pkg
// Shared constants, command codes and status type of the point set normalizer.
// ----------------------------------------------------------------------------
package psn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_W + 1;
    localparam int SUM_W      = 40;
    localparam int SQ2_W      = 33;
    localparam int NUM_W      = SQ2_W + CNT_W;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = NUM_W;
    localparam int IT_W       = $clog2(NUM_W);

    // round(sqrt(2) * 2^32)
    localparam logic [SQ2_W-1:0] SQRT2_Q32 = 33'd6074001000;

    // Datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_DIFF,
        OP_SQA,
        OP_SQB,
        OP_QFORM,
        OP_ROOT,
        OP_ACC,
        OP_DIVINIT,
        OP_DIV,
        OP_SCALE,
        OP_MULW,
        OP_MULH,
        OP_SPANH,
        OP_MULX,
        OP_MULY,
        OP_EMIT
    } t_op;

    // Datapath status
    typedef struct packed {
        logic last_pt;
        logic root_last;
        logic div_last;
    } t_dp_status;

endpackage

/* rtl/psn_datapath.sv */
// ----------------------------------------------------------------------------
// psn_datapath
// Point store, bounding box, shared multiplier, square root and divide units.
// ----------------------------------------------------------------------------
module psn_datapath import psn_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_op                 i_op,
    input  logic signed [31:0]  i_x_coord,
    input  logic signed [31:0]  i_y_coord,
    output t_dp_status          o_status,
    output logic                o_valid,
    output logic signed [31:0]  o_norm_x,
    output logic signed [31:0]  o_norm_y,
    output logic [5:0]          o_point_index,
    output logic [31:0]         o_scale_factor,
    output logic [31:0]         o_box_width,
    output logic [31:0]         o_box_height,
    output logic                o_degenerate,
    output logic                o_dropped,
    output logic                o_last_result
);

    // round, shift by 16 and saturate an unsigned span product
    function automatic logic [31:0] span_round(input logic [63:0] p);
        logic [64:0] t;
        t = {1'b0, p} + 65'h8000;
        return (|t[64:48]) ? 32'hFFFF_FFFF : t[47:16];
    endfunction

    // round, shift by 17, apply sign and saturate a coordinate product
    function automatic logic [31:0] coord_round(input logic [63:0] p, input logic neg);
        logic [64:0] t;
        logic [47:0] r;
        logic [31:0] m;
        t = {1'b0, p} + 65'h1_0000;
        r = t[64:17];
        if (neg) begin
            m = (r > 48'h8000_0000) ? 32'h8000_0000 : r[31:0];
            return 32'd0 - m;
        end
        return (r > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    logic [63:0]          mem [MAX_POINTS];
    logic [63:0]          r_rd;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_ovf;
    logic signed [31:0]   r_minx, r_maxx, r_miny, r_maxy;
    logic [PT_W-1:0]      r_k;
    logic [31:0]          r_a, r_b;
    logic                 r_xneg, r_yneg;
    logic [63:0]          r_prod, r_p1;
    logic [63:0]          r_q;
    logic [33:0]          r_rem;
    logic [31:0]          r_root;
    logic [SUM_W-1:0]     r_sum;
    logic [IT_W-1:0]      r_it;
    logic [NUM_W-1:0]     r_dnum, r_dquo;
    logic [SUM_W-1:0]     r_drem;
    logic                 r_degen;
    logic [31:0]          r_scale, r_bw, r_bh, r_nx;
    logic                 r_valid;
    logic [31:0]          r_ox, r_oy, r_osc, r_obw, r_obh;
    logic [5:0]           r_oidx;
    logic                 r_odeg, r_odrop, r_olast;

    logic signed [32:0]   w_sx, w_sy;
    logic signed [33:0]   w_dx, w_dy;
    logic [33:0]          w_ax, w_ay;
    logic [32:0]          w_w, w_h;
    logic [31:0]          w_ma, w_mb;
    logic [2:0]           w_lo;
    logic [63:0]          w_q;
    logic [35:0]          w_rsh, w_trial;
    logic [SUM_W:0]       w_dsh;
    logic [NUM_W-1:0]     w_num;
    logic                 w_full, w_first, w_last_pt;

    assign w_full    = (r_cnt == CNT_W'(MAX_POINTS));
    assign w_first   = (r_cnt == '0);
    assign w_last_pt = ((CNT_W'(r_k) + 1'b1) == r_cnt);

    // twice the centered coordinates and their magnitudes
    assign w_sx = 33'(r_minx) + 33'(r_maxx);
    assign w_sy = 33'(r_miny) + 33'(r_maxy);
    assign w_dx = $signed({r_rd[63], r_rd[63:32], 1'b0}) - 34'(w_sx);
    assign w_dy = $signed({r_rd[31], r_rd[31:0], 1'b0}) - 34'(w_sy);
    assign w_ax = w_dx[33] ? 34'(-w_dx) : 34'(w_dx);
    assign w_ay = w_dy[33] ? 34'(-w_dy) : 34'(w_dy);
    assign w_w  = 33'(r_maxx) - 33'(r_minx);
    assign w_h  = 33'(r_maxy) - 33'(r_miny);

    // shared multiplier operand select
    always_comb begin
        case (i_op)
            OP_SQA:  begin w_ma = r_a;       w_mb = r_a;     end
            OP_SQB:  begin w_ma = r_b;       w_mb = r_b;     end
            OP_MULW: begin w_ma = w_w[31:0]; w_mb = r_scale; end
            OP_MULH: begin w_ma = w_h[31:0]; w_mb = r_scale; end
            OP_MULX: begin w_ma = r_a;       w_mb = r_scale; end
            OP_MULY: begin w_ma = r_b;       w_mb = r_scale; end
            default: begin w_ma = r_a;       w_mb = r_b;     end
        endcase
    end

    // radicand (a^2 + b^2) / 4, floored
    assign w_lo = {1'b0, r_p1[1:0]} + {1'b0, r_prod[1:0]};
    assign w_q  = {2'b00, r_p1[63:2]} + {2'b00, r_prod[63:2]} + {63'd0, w_lo[2]};

    // one square root digit step, one divide bit step
    assign w_rsh   = {r_rem, r_q[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_dsh   = {r_drem, r_dnum[NUM_W-1]};
    assign w_num   = NUM_W'(SQRT2_Q32) * NUM_W'(r_cnt);

    // point store
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD && !w_full) begin
            mem[r_cnt[PT_W-1:0]] <= {i_x_coord, i_y_coord};
        end
        if (i_op == OP_READ) begin
            r_rd <= mem[r_k];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
            r_it    <= '0;
            r_valid <= 1'b0;
            r_minx  <= '0;
            r_maxx  <= '0;
            r_miny  <= '0;
            r_maxy  <= '0;
        end else begin
            r_valid <= (i_op == OP_EMIT);
            case (i_op)
                OP_LOAD: begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        if (w_first || i_x_coord < r_minx) r_minx <= i_x_coord;
                        if (w_first || i_x_coord > r_maxx) r_maxx <= i_x_coord;
                        if (w_first || i_y_coord < r_miny) r_miny <= i_y_coord;
                        if (w_first || i_y_coord > r_maxy) r_maxy <= i_y_coord;
                    end
                end
                OP_QFORM:   r_it <= '0;
                OP_ROOT:    r_it <= r_it + 1'b1;
                OP_ACC:     r_k  <= r_k + 1'b1;
                OP_DIVINIT: begin
                    r_it <= '0;
                    r_k  <= '0;
                end
                OP_DIV:     r_it <= r_it + 1'b1;
                OP_EMIT: begin
                    if (w_last_pt) begin
                        r_cnt <= '0;
                        r_ovf <= 1'b0;
                        r_k   <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            // first point of a set starts a fresh distance sum
            OP_LOAD: begin
                if (w_first) r_sum <= '0;
            end
            OP_DIFF: begin
                r_a    <= w_ax[31:0];
                r_b    <= w_ay[31:0];
                r_xneg <= w_dx[33];
                r_yneg <= w_dy[33];
            end
            OP_SQA:  r_prod <= w_ma * w_mb;
            OP_SQB: begin
                r_p1   <= r_prod;
                r_prod <= w_ma * w_mb;
            end
            OP_QFORM: begin
                r_q    <= w_q;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_ROOT: begin
                r_q <= {r_q[61:0], 2'b00};
                if (w_rsh >= w_trial) begin
                    r_rem  <= 34'(w_rsh - w_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rsh[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            OP_ACC:  r_sum <= r_sum + SUM_W'(r_root);
            OP_DIVINIT: begin
                r_dnum  <= w_num;
                r_drem  <= '0;
                r_degen <= (r_sum == '0);
            end
            OP_DIV: begin
                r_dnum <= {r_dnum[NUM_W-2:0], 1'b0};
                if (w_dsh >= {1'b0, r_sum}) begin
                    r_drem <= SUM_W'(w_dsh - {1'b0, r_sum});
                    r_dquo <= {r_dquo[NUM_W-2:0], 1'b1};
                end else begin
                    r_drem <= w_dsh[SUM_W-1:0];
                    r_dquo <= {r_dquo[NUM_W-2:0], 1'b0};
                end
            end
            OP_SCALE: begin
                if (r_degen)                   r_scale <= '0;
                else if (|r_dquo[NUM_W-1:32])  r_scale <= 32'hFFFF_FFFF;
                else                           r_scale <= r_dquo[31:0];
            end
            OP_MULW: r_prod <= w_ma * w_mb;
            OP_MULH: begin
                r_bw   <= span_round(r_prod);
                r_prod <= w_ma * w_mb;
            end
            OP_SPANH: r_bh <= span_round(r_prod);
            OP_MULX:  r_prod <= w_ma * w_mb;
            OP_MULY: begin
                r_nx   <= coord_round(r_prod, r_xneg);
                r_prod <= w_ma * w_mb;
            end
            OP_EMIT: begin
                r_ox    <= r_nx;
                r_oy    <= coord_round(r_prod, r_yneg);
                r_oidx  <= 6'(r_k);
                r_osc   <= r_scale;
                r_obw   <= r_bw;
                r_obh   <= r_bh;
                r_odeg  <= r_degen;
                r_odrop <= r_ovf;
                r_olast <= w_last_pt;
            end
            default: ;
        endcase
    end

    assign o_status.last_pt   = w_last_pt;
    assign o_status.root_last = (r_it == IT_W'(ROOT_STEPS - 1));
    assign o_status.div_last  = (r_it == IT_W'(DIV_STEPS - 1));

    assign o_valid        = r_valid;
    assign o_norm_x       = r_ox;
    assign o_norm_y       = r_oy;
    assign o_point_index  = r_oidx;
    assign o_scale_factor = r_osc;
    assign o_box_width    = r_obw;
    assign o_box_height   = r_obh;
    assign o_degenerate   = r_odeg;
    assign o_dropped      = r_odrop;
    assign o_last_result  = r_olast;

endmodule

/* rtl/psn_ctrl.sv */
// ----------------------------------------------------------------------------
// psn_ctrl
// Sequencer: load, distance pass, divide, span scaling and output pass.
// ----------------------------------------------------------------------------
module psn_ctrl import psn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_is_last,
    input  t_dp_status  i_status,
    output logic        o_busy,
    output t_op         o_op
);

    typedef enum logic [18:0] {
        S_IDLE  = 19'd1 << 0,
        S_DRD   = 19'd1 << 1,
        S_DDIF  = 19'd1 << 2,
        S_DSQA  = 19'd1 << 3,
        S_DSQB  = 19'd1 << 4,
        S_DQF   = 19'd1 << 5,
        S_DROOT = 19'd1 << 6,
        S_DACC  = 19'd1 << 7,
        S_DVINI = 19'd1 << 8,
        S_DIV   = 19'd1 << 9,
        S_SCALE = 19'd1 << 10,
        S_MULW  = 19'd1 << 11,
        S_MULH  = 19'd1 << 12,
        S_SPANH = 19'd1 << 13,
        S_ORD   = 19'd1 << 14,
        S_ODIF  = 19'd1 << 15,
        S_OMX   = 19'd1 << 16,
        S_OMY   = 19'd1 << 17,
        S_OEMIT = 19'd1 << 18
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_op = OP_LOAD;
                    if (i_is_last) n_state = S_DRD;
                end
            end
            S_DRD:   begin o_op = OP_READ;  n_state = S_DDIF; end
            S_DDIF:  begin o_op = OP_DIFF;  n_state = S_DSQA; end
            S_DSQA:  begin o_op = OP_SQA;   n_state = S_DSQB; end
            S_DSQB:  begin o_op = OP_SQB;   n_state = S_DQF;  end
            S_DQF:   begin o_op = OP_QFORM; n_state = S_DROOT; end
            S_DROOT: begin
                o_op = OP_ROOT;
                if (i_status.root_last) n_state = S_DACC;
            end
            S_DACC: begin
                o_op    = OP_ACC;
                n_state = i_status.last_pt ? S_DVINI : S_DRD;
            end
            S_DVINI: begin o_op = OP_DIVINIT; n_state = S_DIV; end
            S_DIV: begin
                o_op = OP_DIV;
                if (i_status.div_last) n_state = S_SCALE;
            end
            S_SCALE: begin o_op = OP_SCALE; n_state = S_MULW;  end
            S_MULW:  begin o_op = OP_MULW;  n_state = S_MULH;  end
            S_MULH:  begin o_op = OP_MULH;  n_state = S_SPANH; end
            S_SPANH: begin o_op = OP_SPANH; n_state = S_ORD;   end
            S_ORD:   begin o_op = OP_READ;  n_state = S_ODIF;  end
            S_ODIF:  begin o_op = OP_DIFF;  n_state = S_OMX;   end
            S_OMX:   begin o_op = OP_MULX;  n_state = S_OMY;   end
            S_OMY:   begin o_op = OP_MULY;  n_state = S_OEMIT; end
            S_OEMIT: begin
                o_op    = OP_EMIT;
                n_state = i_status.last_pt ? S_IDLE : S_ORD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/point_set_normalizer.sv */
// ----------------------------------------------------------------------------
// point_set_normalizer
// Centers a 2-D Q16.16 point set on its bounding box and scales it so the
// mean distance to the origin is sqrt(2).
// ----------------------------------------------------------------------------
// Points load at one per cycle while busy is low; the point marked last ends
// the set and raises busy. The block then runs a distance pass over every
// point (one shared 32x32 multiplier plus a square root unit giving one
// result bit per cycle), a bit-serial divide for the scale, the box scaling,
// and an output pass over every point. One result appears per output-pass
// point, each on o_valid for exactly one cycle; the receiver must take it
// then. Busy falls as the last result shows.
module point_set_normalizer import psn_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_x_coord,
    input  logic signed [31:0]  i_y_coord,
    input  logic                i_is_last,
    output logic                o_valid,
    output logic signed [31:0]  o_norm_x,
    output logic signed [31:0]  o_norm_y,
    output logic [5:0]          o_point_index,
    output logic [31:0]         o_scale_factor,
    output logic [31:0]         o_box_width,
    output logic [31:0]         o_box_height,
    output logic                o_degenerate,
    output logic                o_dropped,
    output logic                o_last_result
);

    t_op        w_op;
    t_dp_status w_status;

    psn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_is_last),
        .i_status  (w_status),
        .o_busy    (busy),
        .o_op      (w_op)
    );

    psn_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .o_status       (w_status),
        .o_valid        (o_valid),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_point_index  (o_point_index),
        .o_scale_factor (o_scale_factor),
        .o_box_width    (o_box_width),
        .o_box_height   (o_box_height),
        .o_degenerate   (o_degenerate),
        .o_dropped      (o_dropped),
        .o_last_result  (o_last_result)
    );

endmodule

/* rtl/psn_checker.sv */
// ----------------------------------------------------------------------------
// psn_checker
// Port-level checks of the point set normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_set_normalizer_macros.svh"

module psn_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input logic [31:0]  o_norm_x,
    input logic [31:0]  o_norm_y,
    input logic         o_valid,
    input logic [31:0]  o_scale_factor,
    input logic [31:0]  o_box_width,
    input logic [31:0]  o_box_height,
    input logic         o_degenerate,
    input logic         o_last_result
);

    // a degenerate set yields zero scale and zero points
    `PSN_ASSERT_IMP(a_degen_zero, o_valid && o_degenerate, o_scale_factor == '0 && o_norm_x == '0 && o_norm_y == '0, "degenerate result not zero")

    // a degenerate set yields an empty box
    `PSN_ASSERT_IMP(a_degen_box, o_valid && o_degenerate, o_box_width == '0 && o_box_height == '0, "degenerate box not zero")

    // more results follow a result that is not the last
    `PSN_ASSERT_NEXT(a_more_busy, o_valid && !o_last_result, busy && !o_valid, "block idle before last result")

    // busy is low when the last result shows
    `PSN_ASSERT_IMP(a_last_idle, o_valid && o_last_result, !busy, "busy after last result")

    // results only show while the block works or at its end
    `PSN_ASSERT_NEXT(a_no_stray, !busy && !o_valid, !o_valid, "result without work")

endmodule

bind point_set_normalizer psn_checker u_psn_checker (.*);

/* sim/tb_point_set_normalizer.sv */
// ----------------------------------------------------------------------------
// tb_point_set_normalizer
// Self-checking bench: drives point sets through the normalizer with random
// gaps, predicts every normalized point in a class, and compares each strobed
// result field by field against the predicted queue.
// ----------------------------------------------------------------------------
module tb_point_set_normalizer;
    import psn_pkg::*;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic [5:0]         idx;
        logic [31:0]        scale;
        logic [31:0]        bw;
        logic [31:0]        bh;
        logic               degen;
        logic               drop;
        logic               last;
    } t_norm_pt;

    // Point set predictor and pending-result store
    class norm_scoreboard;
        logic signed [31:0] xs[MAX_POINTS];
        logic signed [31:0] ys[MAX_POINTS];
        logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
        int                 n_pts;
        bit                 ovf;
        t_norm_pt           pending[$];
        int                 errors;

        function new();
            n_pts  = 0;
            ovf    = 0;
            errors = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // d in 2^-17 units times Q16.16 scale, rounded and saturated
        function logic [31:0] scale_pt(longint d, longint unsigned s);
            longint unsigned m, r;
            m = (d < 0) ? longint'(-d) : longint'(d);
            r = (m * s + (64'd1 << 16)) >> 17;
            if (d < 0) begin
                if (r > 64'h8000_0000) r = 64'h8000_0000;
                return 32'(64'd0 - r);
            end
            if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
            return r[31:0];
        endfunction

        function logic [31:0] scale_len(longint lo, longint hi, longint unsigned s);
            longint unsigned w, r;
            w = longint'(hi - lo);
            r = (w * s + 64'h8000) >> 16;
            return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y, bit is_last);
            longint          cx, cy, a, b;
            longint unsigned a2, b2, q, sum, s;
            logic [31:0]     bw, bh;
            bit              dg;
            t_norm_pt        p;
            if (n_pts < MAX_POINTS) begin
                xs[n_pts] = x;
                ys[n_pts] = y;
                if (n_pts == 0) begin
                    lo_x = x; hi_x = x; lo_y = y; hi_y = y;
                end else begin
                    if (x < lo_x) lo_x = x;
                    if (x > hi_x) hi_x = x;
                    if (y < lo_y) lo_y = y;
                    if (y > hi_y) hi_y = y;
                end
                n_pts++;
            end else begin
                ovf = 1;
            end
            if (!is_last) return;
            cx  = longint'(lo_x) + longint'(hi_x);
            cy  = longint'(lo_y) + longint'(hi_y);
            sum = 0;
            for (int k = 0; k < n_pts; k++) begin
                a   = 2 * longint'(xs[k]) - cx;
                b   = 2 * longint'(ys[k]) - cy;
                if (a < 0) a = -a;
                if (b < 0) b = -b;
                a2  = a * a;
                b2  = b * b;
                q   = (a2 >> 2) + (b2 >> 2) + (((a2 & 3) + (b2 & 3)) >> 2);
                sum += int_sqrt(q);
            end
            sum &= 64'hFF_FFFF_FFFF;
            dg = (sum == 0);
            s  = 0;
            if (!dg) begin
                s = (64'(SQRT2_Q32) * longint'(n_pts)) / sum;
                if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
            end
            bw = scale_len(lo_x, hi_x, s);
            bh = scale_len(lo_y, hi_y, s);
            for (int k = 0; k < n_pts; k++) begin
                p.nx    = scale_pt(2 * longint'(xs[k]) - cx, s);
                p.ny    = scale_pt(2 * longint'(ys[k]) - cy, s);
                p.idx   = k[5:0];
                p.scale = s[31:0];
                p.bw    = bw;
                p.bh    = bh;
                p.degen = dg;
                p.drop  = ovf;
                p.last  = (k + 1 == n_pts);
                pending.push_back(p);
            end
            n_pts = 0;
            ovf   = 0;
        endfunction

        function void check_result(t_norm_pt got);
            t_norm_pt want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result idx=%0d", got.idx);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp x=%h y=%h i=%0d s=%h w=%h h=%h d=%b o=%b l=%b\n",
                             want.nx, want.ny, want.idx, want.scale, want.bw, want.bh,
                             want.degen, want.drop, want.last,
                             "         got x=%h y=%h i=%0d s=%h w=%h h=%h d=%b o=%b l=%b",
                             got.nx, got.ny, got.idx, got.scale, got.bw, got.bh,
                             got.degen, got.drop, got.last);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_y_coord;
    logic               i_is_last;
    logic               o_valid;
    logic signed [31:0] o_norm_x;
    logic signed [31:0] o_norm_y;
    logic [5:0]         o_point_index;
    logic [31:0]        o_scale_factor;
    logic [31:0]        o_box_width;
    logic [31:0]        o_box_height;
    logic               o_degenerate;
    logic               o_dropped;
    logic               o_last_result;

    norm_scoreboard sb;
    longint         cycle_cnt;
    bit             calm;
    localparam longint CYCLE_LIMIT = 64'd4_000_000;

    point_set_normalizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_point_index  (o_point_index),
        .o_scale_factor (o_scale_factor),
        .o_box_width    (o_box_width),
        .o_box_height   (o_box_height),
        .o_degenerate   (o_degenerate),
        .o_dropped      (o_dropped),
        .o_last_result  (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result capture and watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_point_set_normalizer NOT OK");
            $finish;
        end
        if (i_rst_n && o_valid)
            sb.check_result({o_norm_x, o_norm_y, o_point_index, o_scale_factor,
                             o_box_width, o_box_height, o_degenerate, o_dropped,
                             o_last_result});
    end

    // Present one point and hold until it is accepted; start stays high after
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit is_last);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_is_last <= is_last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_point(x, y, is_last);
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
        endcase
    endfunction

    // Random set of n points
    task automatic send_set(int n);
        int mode;
        mode = $urandom_range(0, 2);
        for (int k = 0; k < n; k++)
            send_point(rand_coord(mode), rand_coord(mode), k == n - 1);
    endtask

    initial begin
        int sent;
        sb        = new();
        cycle_cnt = 0;
        calm      = 0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_is_last = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single point: zero distance sum, degenerate
        send_point(32'sh1234_5678, -32'sd99, 1);
        // Identical points, also degenerate
        send_point(32'sd7, 32'sd7, 0);
        send_point(32'sd7, 32'sd7, 1);
        // Field extremes
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_point(32'sd0, 32'sd0, 1);
        // Tiny spread: distances round to zero, degenerate
        send_point(32'sd0, 32'sd0, 0);
        send_point(32'sd1, -32'sd1, 1);
        // Full store plus dropped points, last one dropped
        for (int k = 0; k < MAX_POINTS + 3; k++)
            send_point($urandom, $urandom, k == MAX_POINTS + 2);
        sent = 8 + MAX_POINTS + 3;

        // Random sets, mostly small with a few large ones
        while (sent < 250) begin
            int n;
            if (sent > 200) calm = 1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
            send_set(n);
            sent += n;
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_point_set_normalizer OK");
        else
            $display("tb_point_set_normalizer NOT OK");
        $finish;
    end
endmodule
